// ----- rtl/dqc_pkg.sv -----
package dqc_pkg;

    // Quarter turn in Q30 radians
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Register indexes of the configuration port
    localparam logic [3:0] REG_PHASE_STEP    = 4'd0;
    localparam logic [3:0] REG_PARK_GAIN_ONE = 4'd1;
    localparam logic [3:0] REG_PARK_GAIN_TWO = 4'd2;
    localparam logic [3:0] REG_INVERSE_GAIN  = 4'd3;
    localparam logic [3:0] REG_PI_GAIN_NOW   = 4'd4;
    localparam logic [3:0] REG_PI_GAIN_PREV  = 4'd5;
    localparam logic [3:0] REG_DECOUPLE_GAIN = 4'd6;
    localparam logic [3:0] REG_D_REFERENCE   = 4'd7;

    // Product shift of the multiply-accumulate unit
    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_13 = 2'd1,
        SH_14 = 2'd2
    } t_shift;

    // One step of the multiply-accumulate unit
    typedef struct packed {
        logic   en;
        logic   clear;
        logic   neg;
        t_shift shift;
    } t_mac_op;

    // Saturate to the signed 16-bit range
    function automatic logic signed [15:0] sat16(logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Quarter sine entry from a Q30 angle, Taylor series to the eleventh power
    function automatic logic [15:0] sine_entry(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        x2 = (x * x) >> 30;
        t  = x;
        s  = x;
        t  = ((t * x2) >> 30) / 64'd6;
        s  = s - t;
        t  = ((t * x2) >> 30) / 64'd20;
        s  = s + t;
        t  = ((t * x2) >> 30) / 64'd42;
        s  = s - t;
        t  = ((t * x2) >> 30) / 64'd72;
        s  = s + t;
        t  = ((t * x2) >> 30) / 64'd110;
        s  = s - t;
        r  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        return (r > 64'd32767) ? 16'd32767 : r[15:0];
    endfunction

endpackage

// ----- rtl/dqc_in_if.sv -----
interface dqc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] phase_a_current;
    logic signed [15:0] phase_c_current;

    modport source (output valid, output phase_a_current, output phase_c_current,
                    input ready);
    modport sink   (input valid, input phase_a_current, input phase_c_current,
                    output ready);
endinterface

// ----- rtl/dqc_out_if.sv -----
interface dqc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] duty_a;
    logic signed [15:0] duty_b;
    logic signed [15:0] duty_c;
    logic signed [15:0] d_current;
    logic signed [15:0] q_current;

    modport source (output valid, output duty_a, output duty_b, output duty_c,
                    output d_current, output q_current, input ready);
    modport sink   (input valid, input duty_a, input duty_b, input duty_c,
                    input d_current, input q_current, output ready);
endinterface

// ----- rtl/dqc_mac.sv -----
module dqc_mac
    import dqc_pkg::*;
(
    input  logic               i_clk,
    input  t_mac_op            i_op,
    input  logic signed [32:0] i_a,
    input  logic signed [16:0] i_b,
    output logic signed [63:0] o_acc
);

    logic signed [63:0] r_acc;
    logic signed [63:0] n_acc;
    logic signed [49:0] w_prod;
    logic signed [63:0] w_ext;
    logic signed [63:0] w_term;

    // Multiply, scale and sign the product
    assign w_prod = i_a * i_b;
    assign w_ext  = {{14{w_prod[49]}}, w_prod};

    always_comb begin
        unique case (i_op.shift)
            SH_13:   w_term = w_ext <<< 13;
            SH_14:   w_term = w_ext <<< 14;
            default: w_term = w_ext;
        endcase
        if (i_op.neg) begin
            w_term = -w_term;
        end
        n_acc = (i_op.clear ? 64'sd0 : r_acc) + w_term;
    end

    // Accumulate
    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

// ----- rtl/dq_current_controller.sv -----
// Synchronous-frame PI current controller.
// Input channel i_in carries one word of two phase currents (a and c, Q4.12).
// Output channel o_out carries one word per input word: three phase duty
// values and the d and q currents, all Q4.12 and saturated.
// Each word advances the phase by phase_step, looks up sine and cosine in a
// quarter-wave table, runs the Park transform, two incremental PI loops,
// cross decoupling and the inverse transform.
// All arithmetic goes through one shared multiply-accumulate unit, one
// product per cycle, under a 22-step sequencer. A new word is accepted
// only after the previous one has passed into the output register. The
// input is ready only while the sequencer is idle.
// When the receiver stalls, the finished word waits in the output register;
// the next word is still accepted and computed, and it waits in the last
// step until the output register frees.
// Reset clears the phase, the PI history and the output valid, and loads
// the register defaults. Registers are written through i_cfg_we, i_cfg_idx
// and i_cfg_data; indexes beyond seven are ignored.
module dq_current_controller
    import dqc_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    dqc_in_if.sink      i_in,
    dqc_out_if.source   o_out
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);

    // Sequencer steps
    localparam logic [4:0] S_W_A    = 5'd0;
    localparam logic [4:0] S_W_C    = 5'd1;
    localparam logic [4:0] S_ID_S   = 5'd2;
    localparam logic [4:0] S_ID_C   = 5'd3;
    localparam logic [4:0] S_IQ_C   = 5'd4;
    localparam logic [4:0] S_IQ_S   = 5'd5;
    localparam logic [4:0] S_UD_NOW = 5'd6;
    localparam logic [4:0] S_UD_PRV = 5'd7;
    localparam logic [4:0] S_UQ_NOW = 5'd8;
    localparam logic [4:0] S_UQ_PRV = 5'd9;
    localparam logic [4:0] S_DD     = 5'd10;
    localparam logic [4:0] S_DQ     = 5'd11;
    localparam logic [4:0] S_P_S    = 5'd12;
    localparam logic [4:0] S_P_C    = 5'd13;
    localparam logic [4:0] S_Q_C    = 5'd14;
    localparam logic [4:0] S_Q_S    = 5'd15;
    localparam logic [4:0] S_DA     = 5'd16;
    localparam logic [4:0] S_DB_G   = 5'd17;
    localparam logic [4:0] S_DB_P   = 5'd18;
    localparam logic [4:0] S_DC_G   = 5'd19;
    localparam logic [4:0] S_DC_P   = 5'd20;
    localparam logic [4:0] S_LAST   = 5'd21;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef enum logic [3:0] {
        WB_NONE, WB_W, WB_P, WB_Q, WB_ID, WB_IQ, WB_UD, WB_UQ,
        WB_DD, WB_DQ, WB_DA, WB_DB, WB_DC
    } t_wb;

    t_state r_state;
    logic [4:0] r_step;

    // Configuration registers
    logic [15:0]        r_phase_step;
    logic signed [15:0] r_g1, r_g2, r_g3, r_kp, r_ki, r_kdq, r_dref;

    // Working registers
    logic [15:0]        r_phase;
    logic signed [15:0] r_ia, r_ic, r_sin, r_cos;
    logic signed [32:0] r_w, r_p, r_q;
    logic signed [15:0] r_id, r_iq, r_ed, r_eq;
    logic signed [15:0] r_led, r_lod, r_leq, r_loq;
    logic signed [15:0] r_dd, r_dq, r_da, r_db, r_dc;

    // Output register
    logic               r_out_valid;
    logic signed [15:0] r_o_a, r_o_b, r_o_c, r_o_d, r_o_q;

    // Sine table and lookup
    logic [15:0]        w_tab [SINE_TABLE_DEPTH];
    logic [15:0]        w_angle;
    logic [15:0]        w_lane_ang [2];
    logic signed [15:0] w_lane_val [2];
    logic [IW+13:0]     w_lane_prod [2];
    logic [IW-1:0]      w_lane_i [2];
    logic [IW-1:0]      w_lane_j [2];
    logic [15:0]        w_lane_m [2];

    // Sequencer outputs
    t_mac_op            w_op;
    logic signed [32:0] w_a;
    logic signed [16:0] w_b;
    t_wb                w_wb;
    logic signed [63:0] w_acc;

    // Writeback
    logic signed [63:0] w_rnd29, w_rnd14, w_rnd, w_sum;
    logic signed [15:0] w_add, w_val;
    logic               w_sub;
    logic signed [16:0] w_err_d, w_err_q;

    logic w_accept;
    logic w_load;

    genvar k;
    generate
        for (k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_tab
            localparam logic [63:0] X = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
            assign w_tab[k] = sine_entry(X);
        end
    endgenerate

    assign w_angle       = r_phase + r_phase_step;
    assign w_lane_ang[0] = w_angle;
    assign w_lane_ang[1] = w_angle + 16'h4000;

    // Look up sine and cosine of the advanced phase
    always_comb begin
        for (int n = 0; n < 2; n++) begin
            w_lane_prod[n] = (IW + 14)'(w_lane_ang[n][13:0])
                             * (IW + 14)'(SINE_TABLE_DEPTH);
            w_lane_i[n]    = w_lane_prod[n][IW+13:14];
            w_lane_j[n]    = w_lane_ang[n][14] ? IW'(SINE_TABLE_DEPTH) - w_lane_i[n]
                                               : w_lane_i[n];
            w_lane_m[n]    = (w_lane_j[n] >= IW'(SINE_TABLE_DEPTH)) ? 16'd32767
                                                                  : w_tab[w_lane_j[n][AW-1:0]];
            w_lane_val[n]  = w_lane_ang[n][15] ? -$signed(w_lane_m[n]) : $signed(w_lane_m[n]);
        end
    end

    assign w_accept    = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_load      = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    // Pick operands and writeback for the current step
    always_comb begin
        w_op  = '{en: 1'b1, clear: 1'b0, neg: 1'b0, shift: SH_0};
        w_a   = '0;
        w_b   = '0;
        w_wb  = WB_NONE;
        unique case (r_step)
            S_W_A: begin
                w_a = 33'(r_g1); w_b = 17'(r_ia); w_op.clear = 1'b1;
            end
            S_W_C: begin
                w_a = 33'(r_g2); w_b = 17'(r_ic);
            end
            S_ID_S: begin
                w_a = 33'(r_sin); w_b = 17'(r_ia); w_op.clear = 1'b1;
                w_op.shift = SH_14; w_wb = WB_W;
            end
            S_ID_C: begin
                w_a = r_w; w_b = 17'(r_cos);
            end
            S_IQ_C: begin
                w_a = 33'(r_cos); w_b = 17'(r_ia); w_op.clear = 1'b1;
                w_op.shift = SH_14; w_wb = WB_ID;
            end
            S_IQ_S: begin
                w_a = r_w; w_b = 17'(r_sin); w_op.neg = 1'b1;
            end
            S_UD_NOW: begin
                w_a = 33'(r_ed); w_b = 17'(r_kp); w_op.clear = 1'b1; w_wb = WB_IQ;
            end
            S_UD_PRV: begin
                w_a = 33'(r_led); w_b = 17'(r_ki);
            end
            S_UQ_NOW: begin
                w_a = 33'(r_eq); w_b = 17'(r_kp); w_op.clear = 1'b1; w_wb = WB_UD;
            end
            S_UQ_PRV: begin
                w_a = 33'(r_leq); w_b = 17'(r_ki);
            end
            S_DD: begin
                w_a = 33'(r_kdq); w_b = 17'(r_iq); w_op.clear = 1'b1; w_wb = WB_UQ;
            end
            S_DQ: begin
                w_a = 33'(r_kdq); w_b = 17'(r_id); w_op.clear = 1'b1; w_wb = WB_DD;
            end
            S_P_S: begin
                w_a = 33'(r_sin); w_b = 17'(r_dd); w_op.clear = 1'b1; w_wb = WB_DQ;
            end
            S_P_C: begin
                w_a = 33'(r_cos); w_b = 17'(r_dq);
            end
            S_Q_C: begin
                w_a = 33'(r_cos); w_b = 17'(r_dd); w_op.clear = 1'b1; w_wb = WB_P;
            end
            S_Q_S: begin
                w_a = 33'(r_sin); w_b = 17'(r_dq); w_op.neg = 1'b1;
            end
            S_DA: begin
                w_a = r_p; w_b = 17'sd1; w_op.clear = 1'b1; w_op.shift = SH_14;
                w_wb = WB_Q;
            end
            S_DB_G: begin
                w_a = r_q; w_b = 17'(r_g3); w_op.clear = 1'b1; w_op.neg = 1'b1;
                w_wb = WB_DA;
            end
            S_DB_P: begin
                w_a = r_p; w_b = 17'sd1; w_op.neg = 1'b1; w_op.shift = SH_13;
            end
            S_DC_G: begin
                w_a = r_q; w_b = 17'(r_g3); w_op.clear = 1'b1; w_wb = WB_DB;
            end
            S_DC_P: begin
                w_a = r_p; w_b = 17'sd1; w_op.neg = 1'b1; w_op.shift = SH_13;
            end
            S_LAST: begin
                w_op.en = 1'b0; w_wb = WB_DC;
            end
            default: begin
                w_op.en = 1'b0;
            end
        endcase
        if (r_state != ST_RUN) begin
            w_op.en = 1'b0;
            w_wb    = WB_NONE;
        end
    end

    dqc_mac u_mac (
        .i_clk (i_clk),
        .i_op  (w_op),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_acc (w_acc)
    );

    // Round the accumulator, add the PI or decoupling term, saturate
    assign w_rnd29 = (w_acc + 64'sd268435456) >>> 29;
    assign w_rnd14 = (w_acc + 64'sd8192) >>> 14;

    always_comb begin
        w_rnd = w_rnd29;
        w_add = '0;
        w_sub = 1'b0;
        unique case (w_wb)
            WB_UD: begin
                w_rnd = w_rnd14; w_add = r_lod;
            end
            WB_UQ: begin
                w_rnd = w_rnd14; w_add = r_loq;
            end
            WB_DD: begin
                w_rnd = w_rnd14; w_add = r_lod;
            end
            WB_DQ: begin
                w_rnd = w_rnd14; w_add = r_loq; w_sub = 1'b1;
            end
            default: begin
                w_rnd = w_rnd29;
            end
        endcase
        w_sum   = w_sub ? (64'(w_add) - w_rnd) : (w_rnd + 64'(w_add));
        w_val   = sat16(w_sum);
        w_err_d = 17'(r_dref) - 17'(w_val);
        w_err_q = 17'sd0 - 17'(w_val);
    end

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= 16'd0;
            r_g1         <= 16'sd9459;
            r_g2         <= 16'sd18919;
            r_g3         <= 16'sd14189;
            r_kp         <= 16'sd0;
            r_ki         <= 16'sd0;
            r_kdq        <= 16'sd0;
            r_dref       <= -16'sd14336;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PHASE_STEP:    r_phase_step <= i_cfg_data;
                REG_PARK_GAIN_ONE: r_g1         <= i_cfg_data;
                REG_PARK_GAIN_TWO: r_g2         <= i_cfg_data;
                REG_INVERSE_GAIN:  r_g3         <= i_cfg_data;
                REG_PI_GAIN_NOW:   r_kp         <= i_cfg_data;
                REG_PI_GAIN_PREV:  r_ki         <= i_cfg_data;
                REG_DECOUPLE_GAIN: r_kdq        <= i_cfg_data;
                REG_D_REFERENCE:   r_dref       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= S_W_A;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_RUN;
                        r_step  <= S_W_A;
                    end
                end
                ST_RUN: begin
                    if (r_step == S_LAST) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Hold phase and PI history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 16'd0;
            r_led   <= 16'sd0;
            r_lod   <= 16'sd0;
            r_leq   <= 16'sd0;
            r_loq   <= 16'sd0;
        end else begin
            if (w_accept) begin
                r_phase <= w_angle;
            end
            if (w_wb == WB_UD) begin
                r_lod <= w_val;
                r_led <= r_ed;
            end
            if (w_wb == WB_UQ) begin
                r_loq <= w_val;
                r_leq <= r_eq;
            end
        end
    end

    // Capture the word and write back step results
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ia  <= i_in.phase_a_current;
            r_ic  <= i_in.phase_c_current;
            r_sin <= w_lane_val[0];
            r_cos <= w_lane_val[1];
        end
        unique case (w_wb)
            WB_W:  r_w <= w_acc[32:0];
            WB_P:  r_p <= w_acc[32:0];
            WB_Q:  r_q <= w_acc[32:0];
            WB_ID: begin
                r_id <= w_val;
                r_ed <= sat16(64'(w_err_d));
            end
            WB_IQ: begin
                r_iq <= w_val;
                r_eq <= sat16(64'(w_err_q));
            end
            WB_DD: r_dd <= w_val;
            WB_DQ: r_dq <= w_val;
            WB_DA: r_da <= w_val;
            WB_DB: r_db <= w_val;
            WB_DC: r_dc <= w_val;
            default: ;
        endcase
    end

    // Hold the output word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_a <= r_da;
            r_o_b <= r_db;
            r_o_c <= r_dc;
            r_o_d <= r_id;
            r_o_q <= r_iq;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.duty_a    = r_o_a;
    assign o_out.duty_b    = r_o_b;
    assign o_out.duty_c    = r_o_c;
    assign o_out.d_current = r_o_d;
    assign o_out.q_current = r_o_q;

endmodule

// ----- tb/sv/dqc_scoreboard.sv -----
`timescale 1ns / 100ps

// Predicts the controller word by word and checks the duty and current outputs
class dqc_scoreboard;
    typedef struct packed {
        logic signed [15:0] duty_a;
        logic signed [15:0] duty_b;
        logic signed [15:0] duty_c;
        logic signed [15:0] d_current;
        logic signed [15:0] q_current;
    } t_duty_word;

    logic [15:0]        cfg_regs [8];
    logic [15:0]        quarter_rom [256];
    logic [15:0]        angle;
    int                 d_err_hist, d_out_hist, q_err_hist, q_out_hist;
    t_duty_word         pending_duty[$];
    int                 mismatches;
    int                 words_checked;

    function new();
        mismatches = 0;
        words_checked = 0;
        build_rom();
        reset_state();
    endfunction

    // Quarter-wave sine from a Taylor series in Q30
    function void build_rom();
        longint unsigned x, x2, t, s, r;
        for (int k = 0; k < 256; k++) begin
            x  = (64'd1686629713 * k) / 256;
            x2 = (x * x) >> 30;
            t  = x;
            s  = x;
            for (int n = 1; n <= 5; n++) begin
                t = ((t * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1) s = s - t;
                else s = s + t;
            end
            r = (s * 32767 + (64'd1 << 29)) >> 30;
            quarter_rom[k] = (r > 32767) ? 16'd32767 : r[15:0];
        end
    endfunction

    function void reset_state();
        cfg_regs[0] = 16'd0;
        cfg_regs[1] = 16'd9459;
        cfg_regs[2] = 16'd18919;
        cfg_regs[3] = 16'd14189;
        cfg_regs[4] = 16'd0;
        cfg_regs[5] = 16'd0;
        cfg_regs[6] = 16'd0;
        cfg_regs[7] = 16'hc800;
        angle = 16'd0;
        d_err_hist = 0;
        d_out_hist = 0;
        q_err_hist = 0;
        q_out_hist = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [15:0] data);
        if (idx < 8) cfg_regs[idx[2:0]] = data;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Round half up, then floor shift
    function automatic longint round_shift(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint sreg(int idx);
        return longint'($signed(cfg_regs[idx]));
    endfunction

    function automatic longint sine_lookup(logic [15:0] ang);
        int unsigned i;
        int unsigned j;
        longint m;
        i = (int'(ang[13:0]) * 256) >> 14;
        j = ang[14] ? 256 - i : i;
        m = (j >= 256) ? 32767 : longint'(quarter_rom[j]);
        return ang[15] ? -m : m;
    endfunction

    function automatic longint pi_update(longint ref_val, longint meas,
                                         ref int err_hist, ref int out_hist);
        longint e0, acc, u0;
        e0 = clamp16(ref_val - meas);
        acc = e0 * sreg(4) + longint'(err_hist) * sreg(5);
        u0 = clamp16(round_shift(acc, 14) + out_hist);
        err_hist = int'(e0);
        out_hist = int'(u0);
        return u0;
    endfunction

    // Note an accepted current word and queue its expected duty word
    function void note_currents(logic signed [15:0] ia_in, logic signed [15:0] ic_in);
        longint ia, ic, g1, g2, g3, kdq, s, c, acc, id, iq, ud, uq, dd, dq;
        t_duty_word w;
        ia = ia_in;
        ic = ic_in;
        g1 = sreg(1);
        g2 = sreg(2);
        g3 = sreg(3);
        kdq = sreg(6);
        angle = angle + cfg_regs[0];
        s = sine_lookup(angle);
        c = sine_lookup(angle + 16'h4000);
        acc = (s * 16384 + c * g1) * ia + c * g2 * ic;
        id = clamp16(round_shift(acc, 29));
        acc = (c * 16384 - s * g1) * ia - s * g2 * ic;
        iq = clamp16(round_shift(acc, 29));
        ud = pi_update(sreg(7), id, d_err_hist, d_out_hist);
        uq = pi_update(0, iq, q_err_hist, q_out_hist);
        dd = clamp16(ud + round_shift(kdq * iq, 14));
        dq = clamp16(uq - round_shift(kdq * id, 14));
        acc = s * 16384 * dd + c * 16384 * dq;
        w.duty_a = 16'(clamp16(round_shift(acc, 29)));
        acc = -(g3 * c + s * 8192) * dd + (g3 * s - c * 8192) * dq;
        w.duty_b = 16'(clamp16(round_shift(acc, 29)));
        acc = (g3 * c - s * 8192) * dd - (c * 8192 + g3 * s) * dq;
        w.duty_c = 16'(clamp16(round_shift(acc, 29)));
        w.d_current = 16'(id);
        w.q_current = 16'(iq);
        pending_duty.push_back(w);
    endfunction

    // Check one output word against the oldest expectation
    function void check_duty(t_duty_word got);
        t_duty_word want;
        if (pending_duty.size() == 0) begin
            $error("output word with nothing expected");
            mismatches++;
            return;
        end
        want = pending_duty.pop_front();
        words_checked++;
        if (got.duty_a !== want.duty_a) begin
            $error("duty_a expected %0d got %0d", want.duty_a, got.duty_a);
            mismatches++;
        end
        if (got.duty_b !== want.duty_b) begin
            $error("duty_b expected %0d got %0d", want.duty_b, got.duty_b);
            mismatches++;
        end
        if (got.duty_c !== want.duty_c) begin
            $error("duty_c expected %0d got %0d", want.duty_c, got.duty_c);
            mismatches++;
        end
        if (got.d_current !== want.d_current) begin
            $error("d_current expected %0d got %0d", want.d_current, got.d_current);
            mismatches++;
        end
        if (got.q_current !== want.q_current) begin
            $error("q_current expected %0d got %0d", want.q_current, got.q_current);
            mismatches++;
        end
    endfunction
endclass

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import dqc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    int          send_idle_pct;
    int          sink_stall_pct;
    int          words_sent;

    dqc_in_if  cur_ch ();
    dqc_out_if duty_ch ();
    dqc_scoreboard board;

    dq_current_controller i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (cur_ch.sink),
        .o_out      (duty_ch.source)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Random receiver stall, changed on the falling edge
    always @(negedge i_clk) begin
        duty_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Check each output word at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && duty_ch.valid && duty_ch.ready) begin
            board.check_duty({duty_ch.duty_a, duty_ch.duty_b, duty_ch.duty_c,
                              duty_ch.d_current, duty_ch.q_current});
        end
    end

    // Send one current word, with random idle cycles ahead of it
    task automatic send_currents(logic [15:0] ia, logic [15:0] ic);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            cur_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cur_ch.valid <= 1'b1;
        cur_ch.phase_a_current <= ia;
        cur_ch.phase_c_current <= ic;
        @(posedge i_clk);
        while (!cur_ch.ready) @(posedge i_clk);
        board.note_currents(ia, ic);
        words_sent++;
    endtask

    // Drop valid, drain outstanding words, then let the sequencer settle
    task automatic drain();
        @(negedge i_clk);
        cur_ch.valid <= 1'b0;
        while (board.pending_duty.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        board.write_reg(idx, data);
    endtask

    task automatic write_all(logic [15:0] step, logic [15:0] g1, logic [15:0] g2,
                             logic [15:0] g3, logic [15:0] kp, logic [15:0] ki,
                             logic [15:0] kdq, logic [15:0] dref);
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_PARK_GAIN_ONE, g1);
        write_reg(REG_PARK_GAIN_TWO, g2);
        write_reg(REG_INVERSE_GAIN, g3);
        write_reg(REG_PI_GAIN_NOW, kp);
        write_reg(REG_PI_GAIN_PREV, ki);
        write_reg(REG_DECOUPLE_GAIN, kdq);
        write_reg(REG_D_REFERENCE, dref);
    endtask

    // Mostly moderate currents, sometimes full range or rails
    function automatic logic [15:0] pick_current();
        case ($urandom_range(9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2, 3:    return 16'($urandom);
            default: return 16'($signed($urandom_range(16384)) - 8192);
        endcase
    endfunction

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct  = idle;
        sink_stall_pct = stall;
        repeat (n) send_currents(pick_current(), pick_current());
    endtask

    initial begin
        board = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        cur_ch.valid = 1'b0;
        cur_ch.phase_a_current = '0;
        cur_ch.phase_c_current = '0;
        duty_ch.ready = 1'b0;
        send_idle_pct = 0;
        sink_stall_pct = 0;
        words_sent = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset defaults, current rails and zero
        send_currents(16'h7fff, 16'h7fff);
        send_currents(16'h8000, 16'h8000);
        send_currents(16'h7fff, 16'h8000);
        send_currents(16'h8000, 16'h7fff);
        send_currents(16'h0000, 16'h0000);
        send_currents(16'hffff, 16'h0001);
        drain();

        // Directed: quarter-turn steps hit every quadrant and the table end
        write_all(16'h4000, 16'd9459, 16'd18919, 16'd14189, 16'd8000, 16'hf000,
                  16'd4000, 16'h1000);
        repeat (5) send_currents(16'h1000, 16'hf000);
        drain();
        write_reg(REG_PHASE_STEP, 16'hffff);
        repeat (3) send_currents(16'h7fff, 16'h7fff);
        drain();

        // Directed: gain extremes drive every saturation
        write_all(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                  16'h7fff, 16'h7fff);
        repeat (4) send_currents(16'h8000, 16'h7fff);
        drain();
        write_all(16'h0001, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                  16'h8000, 16'h8000);
        repeat (4) send_currents(16'h7fff, 16'h8000);
        drain();

        // Random phases under changing settings and flow control
        write_all(16'd1234, 16'd9459, 16'd18919, 16'd14189, 16'd6000, 16'hec00,
                  16'd300, 16'hc800);
        random_phase(300, 0, 0);
        random_phase(250, 66, 0);
        drain();
        write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        random_phase(250, 0, 66);
        random_phase(250, 35, 35);
        drain();
        write_all(16'($urandom_range(2000)), 16'd9459, 16'd18919, 16'd14189,
                  16'($urandom_range(12000)), 16'($signed(-$urandom_range(12000))),
                  16'($urandom_range(2000)), 16'($urandom));
        random_phase(300, 0, 0);
        random_phase(200, 35, 35);
        drain();
        // Out-of-range index must leave the registers alone
        write_reg(4'd8, 16'h5555);
        write_reg(4'd15, 16'haaaa);
        random_phase(200, 66, 66);
        drain();

        $display("Sent %0d current words under directed and random settings with idle",
                 words_sent);
        $display("senders and stalling receivers; %0d duty words checked.",
                 board.words_checked);
        if (board.mismatches == 0 && board.pending_duty.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Guard against a hang
    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
